>>> rtl/core/lop_pkg.sv
// ----------------------------------------------------------------------------
// Lattice order parameter package
// Shared widths, register codes, divider states and the cosine term table.
// ----------------------------------------------------------------------------
package lop_pkg;

  // Pass size and cosine table resolution.
  localparam int MAX_MOLECULES  = 1048576;
  localparam int COS_TABLE_BITS = 10;

  // Field widths.
  localparam int POS_W  = 32;
  localparam int INV_W  = 32;
  localparam int TERM_W = 16;
  localparam int LAM_W  = 16;
  localparam int SUM_W  = 40;
  localparam int CNT_W  = $clog2(MAX_MOLECULES + 1);
  localparam int TSUM_W = TERM_W + 2;

  // The phase keeps 40 fraction bits; the table index is its top bits.
  localparam int FRAC_W = 40;
  localparam int COS_N  = 1 << COS_TABLE_BITS;

  // Divider widths: divisor is three times the count, numerator the rounded sum.
  localparam int DIV_W  = CNT_W + 2;
  localparam int NUM_W  = SUM_W + 1;
  localparam int STEP_W = $clog2(NUM_W);

  localparam logic [LAM_W-1:0] LAMBDA_ONE = LAM_W'(32768);

  // Configuration port.
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_INV_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INV_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INV_Z = 2'd2;
  localparam logic [INV_W-1:0] INV_RESET = 32'h0100_0000;

  // Divider sequencer states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_PREP,
    DIV_RUN,
    DIV_HOLD
  } div_state_t;

  // End-of-pass totals handed from the accumulator to the divider.
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } lop_pass_t;

  // Finished result from the divider.
  typedef struct packed {
    logic             valid;
    logic [LAM_W-1:0] lambda;
    logic [CNT_W-1:0] cnt;
  } lop_res_t;

  typedef logic [TERM_W-1:0] cos_lut_t [COS_N];

  // cos(pi/2 * x) for x in Q30 over [0,1], by an even polynomial in Q30.
  function automatic longint unsigned quarter_cos(input longint unsigned x);
    longint unsigned y;
    longint unsigned h;
    y = (x * x) >> 30;
    h = 64'd987053 - ((y * 64'd27061) >> 30);
    h = 64'd22401924 - ((y * h) >> 30);
    h = 64'd272375465 - ((y * h) >> 30);
    h = 64'd1324675879 - ((y * h) >> 30);
    h = (y * h) >> 30;
    return (h >= 64'd1073741824) ? 64'd0 : (64'd1073741824 - h);
  endfunction

  // Builds 0.5*cos(2*pi*i/N)+0.5 in Q1.15, rounded half up, from quarter waves.
  function automatic cos_lut_t build_cos_lut();
    cos_lut_t        lut;
    longint unsigned q;
    longint unsigned r;
    longint unsigned x;
    longint unsigned c;
    longint unsigned v;
    longint unsigned one;
    int              qbits;
    qbits = COS_TABLE_BITS - 2;
    one   = 64'd1073741824;
    for (int i = 0; i < COS_N; i++) begin
      q = (longint'(i) >> qbits) & 64'd3;
      r = longint'(i) & ((64'd1 << qbits) - 64'd1);
      x = r << (30 - qbits);
      case (q)
        64'd0:   begin c = quarter_cos(x);       v = one + c; end
        64'd1:   begin c = quarter_cos(one - x); v = one - c; end
        64'd2:   begin c = quarter_cos(x);       v = one - c; end
        default: begin c = quarter_cos(one - x); v = one + c; end
      endcase
      lut[i] = TERM_W'((v + 64'd32768) >> 16);
    end
    return lut;
  endfunction

  localparam cos_lut_t COS_LUT = build_cos_lut();

endpackage

>>> rtl/core/lop_in_if.sv
// ----------------------------------------------------------------------------
// Lattice order parameter input channel
// One molecule centre-of-mass position per word, with a pass-end marker.
// ----------------------------------------------------------------------------
interface lop_in_if
  import lop_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    last;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output last,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, input last,
                  output ready);
endinterface

>>> rtl/core/lop_out_if.sv
// ----------------------------------------------------------------------------
// Lattice order parameter result channel
// One order parameter and molecule count per measurement pass.
// ----------------------------------------------------------------------------
interface lop_out_if
  import lop_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [LAM_W-1:0] lambda;
  logic [CNT_W-1:0] molecule_count;

  modport source (output valid, output lambda, output molecule_count, input ready);
  modport sink   (input valid, input lambda, input molecule_count, output ready);
endinterface

>>> rtl/core/lop_lane.sv
// ----------------------------------------------------------------------------
// Lattice order parameter axis lane
// Forms the phase of one coordinate and looks up its cosine term.
// ----------------------------------------------------------------------------
module lop_lane
  import lop_pkg::*;
(
  input  logic                    clk,
  input  logic signed [POS_W-1:0] pos,
  input  logic        [INV_W-1:0] inv,
  output logic       [TERM_W-1:0] term_r
);

  logic signed [POS_W:0]          d;
  logic signed [2*POS_W+1:0]      prod;
  logic [COS_TABLE_BITS-1:0]      idx_nxt;
  logic [COS_TABLE_BITS-1:0]      idx_r;

  // Offset by one half, then scale; only the fraction bits of the phase matter,
  // and those are the same for the signed and the wrapped product.
  always_comb begin
    d       = $signed({pos[POS_W-1], pos}) - $signed((POS_W+1)'(32768));
    prod    = d * $signed({1'b0, inv});
    idx_nxt = prod[FRAC_W-1 -: COS_TABLE_BITS];
  end

  // Product stage, then a registered read of the term table.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    term_r <= COS_LUT[idx_r];
  end

endmodule

>>> rtl/core/lop_accum.sv
// ----------------------------------------------------------------------------
// Lattice order parameter accumulator
// Merges the three lane terms and keeps the running sum and molecule count.
// ----------------------------------------------------------------------------
module lop_accum
  import lop_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid,
  input  logic              last,
  input  logic [TERM_W-1:0] term_x,
  input  logic [TERM_W-1:0] term_y,
  input  logic [TERM_W-1:0] term_z,
  output lop_pass_t         pass_r
);

  logic [TSUM_W-1:0] tsum;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [SUM_W-1:0]  sum_add;
  logic [CNT_W-1:0]  cnt_add;
  logic              room;
  lop_pass_t         pass_nxt;

  // Merge the lanes; a full pass stops taking molecules but still closes.
  always_comb begin
    tsum     = TSUM_W'(term_x) + TSUM_W'(term_y) + TSUM_W'(term_z);
    room     = cnt_r < CNT_W'(MAX_MOLECULES);
    sum_add  = room ? SUM_W'(sum_r + SUM_W'(tsum)) : sum_r;
    cnt_add  = room ? CNT_W'(cnt_r + CNT_W'(1)) : cnt_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    pass_nxt = '0;
    if (valid) begin
      if (last) begin
        pass_nxt.valid = 1'b1;
        pass_nxt.sum   = sum_add;
        pass_nxt.cnt   = cnt_add;
        sum_nxt        = '0;
        cnt_nxt        = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      cnt_r        <= '0;
      pass_r.valid <= 1'b0;
    end else begin
      sum_r        <= sum_nxt;
      cnt_r        <= cnt_nxt;
      pass_r.valid <= pass_nxt.valid;
    end
    pass_r.sum <= pass_nxt.sum;
    pass_r.cnt <= pass_nxt.cnt;
  end

endmodule

>>> rtl/core/lop_div.sv
// ----------------------------------------------------------------------------
// Lattice order parameter divider
// Restoring division of the rounded term sum by three times the count.
// ----------------------------------------------------------------------------
module lop_div
  import lop_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lop_pass_t pass,
  input  logic      res_taken,
  output lop_res_t  res
);

  div_state_t        state_r;
  div_state_t        state_nxt;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  num_nxt;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  rem_nxt;
  logic [DIV_W-1:0]  div_r;
  logic [DIV_W-1:0]  div_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [DIV_W:0]    trial;
  logic              qbit;

  // Sequencer: load, add half the divisor for rounding, one quotient bit a cycle.
  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    trial     = {rem_r, num_r[NUM_W-1]};
    qbit      = trial >= {1'b0, div_r};
    case (state_r)
      DIV_IDLE: begin
        if (pass.valid) begin
          cnt_nxt   = pass.cnt;
          div_nxt   = DIV_W'({pass.cnt, 1'b0}) + DIV_W'(pass.cnt);
          num_nxt   = NUM_W'(pass.sum);
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = DIV_PREP;
        end
      end
      DIV_PREP: begin
        num_nxt   = num_r + NUM_W'(div_r >> 1);
        state_nxt = DIV_RUN;
      end
      DIV_RUN: begin
        rem_nxt  = qbit ? DIV_W'(trial - {1'b0, div_r}) : DIV_W'(trial);
        num_nxt  = {num_r[NUM_W-2:0], qbit};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NUM_W - 1)) begin
          state_nxt = DIV_HOLD;
        end
      end
      DIV_HOLD: begin
        if (res_taken) begin
          state_nxt = DIV_IDLE;
        end
      end
      default: begin
        state_nxt = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    cnt_r  <= cnt_nxt;
    step_r <= step_nxt;
  end

  // Quotient is clamped to one; an empty pass reads as zero.
  always_comb begin
    res.valid = state_r == DIV_HOLD;
    res.cnt   = cnt_r;
    if (div_r == '0) begin
      res.lambda = '0;
    end else if (num_r > NUM_W'(LAMBDA_ONE)) begin
      res.lambda = LAMBDA_ONE;
    end else begin
      res.lambda = num_r[LAM_W-1:0];
    end
  end

endmodule

>>> rtl/core/lattice_order_parameter_top.sv
// ----------------------------------------------------------------------------
// Lattice order parameter
// Translational order of molecules on a cubic lattice, one position per word.
//
// The input channel (in_s) takes one centre-of-mass position per word, signed
// Q16.16 per axis, and a last flag that closes a measurement pass. Three axis
// lanes each scale the offset coordinate by the reciprocal spacing and look up
// 0.5*cos(2*pi*phase)+0.5; a merge stage sums the lanes into the running total.
// Within a pass a word is taken every cycle. On the last word the pass total is
// divided by three times the count in a restoring divider, one quotient bit a
// cycle, and lambda (Q1.15) with the count is then made valid on out_m; the
// divider runs 41 steps, one per quotient bit.
// in_s.ready stays low from the last word until the result sits in the output
// register, so the next pass starts while that result still waits to be taken.
// A stalled receiver holds the result in the output register and, once a
// further pass ends, the input.
// Reset clears the sum, the count and the channels, and sets each reciprocal
// spacing to 1.0. The APB port (byte addresses 0, 4, 8) holds the spacings,
// which the user must write only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
module lattice_order_parameter_top
  import lop_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lop_in_if.sink            in_s,
  lop_out_if.source         out_m,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [INV_W-1:0]     inv_x_r;
  logic [INV_W-1:0]     inv_y_r;
  logic [INV_W-1:0]     inv_z_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic                 in_acc;
  logic                 pending_r;
  logic                 s1_v_r;
  logic                 s1_last_r;
  logic                 s2_v_r;
  logic                 s2_last_r;
  logic [TERM_W-1:0]    term_x;
  logic [TERM_W-1:0]    term_y;
  logic [TERM_W-1:0]    term_z;
  lop_pass_t            pass;
  lop_res_t             res;
  logic                 out_load;
  logic                 out_valid_r;
  logic [LAM_W-1:0]     lambda_r;
  logic [CNT_W-1:0]     count_r;

  // Register access.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_x_r <= INV_RESET;
      inv_y_r <= INV_RESET;
      inv_z_r <= INV_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INV_X: inv_x_r <= pwdata;
        REG_INV_Y: inv_y_r <= pwdata;
        REG_INV_Z: inv_z_r <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INV_X: prdata = inv_x_r;
      REG_INV_Y: prdata = inv_y_r;
      REG_INV_Z: prdata = inv_z_r;
      default:   prdata = '0;
    endcase
  end

  // Input side: hold off from a pass end until its result is registered.
  assign in_s.ready = !pending_r;
  assign in_acc     = in_s.valid && in_s.ready;
  assign out_load   = res.valid && (!out_valid_r || out_m.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      if (in_acc && in_s.last) begin
        pending_r <= 1'b1;
      end else if (out_load) begin
        pending_r <= 1'b0;
      end
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= in_s.last;
    s2_last_r <= s1_last_r;
  end

  // Axis lanes.
  lop_lane u_lane_x (.clk(clk), .pos(in_s.pos_x), .inv(inv_x_r), .term_r(term_x));
  lop_lane u_lane_y (.clk(clk), .pos(in_s.pos_y), .inv(inv_y_r), .term_r(term_y));
  lop_lane u_lane_z (.clk(clk), .pos(in_s.pos_z), .inv(inv_z_r), .term_r(term_z));

  // Merge and accumulate.
  lop_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid  (s2_v_r),
    .last   (s2_last_r),
    .term_x (term_x),
    .term_y (term_y),
    .term_z (term_z),
    .pass_r (pass)
  );

  // Pass-end division.
  lop_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .pass      (pass),
    .res_taken (out_load),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      lambda_r <= res.lambda;
      count_r  <= res.cnt;
    end
  end

  assign out_m.valid          = out_valid_r;
  assign out_m.lambda         = lambda_r;
  assign out_m.molecule_count = count_r;

endmodule
